// ===== src/page_framebuffer_draw_engine_unit_defines.svh =====
// Assertion macros for the draw engine checker
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_DEFINES_SVH

// checked only while out of reset
`define PFDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PFDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pfde_pkg.sv =====
`default_nettype none

package pfde_pkg;

  localparam int COORD_W     = 8;
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 10;
  localparam int ACT_W       = 3;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [ACT_W-1:0] ACT_PIXEL = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HLINE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_VLINE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RECT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FILL  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd6;

  typedef enum logic [2:0] {
    K_PIXEL,
    K_HLINE,
    K_VLINE,
    K_RECT,
    K_FILL,
    K_CLEAR,
    K_READ,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] ya;
    logic [COORD_W-1:0] xb;
    logic [COORD_W-1:0] yb;
    logic [COORD_W-1:0] cnt;   // run for lines, width for rectangles
    logic [COORD_W-1:0] ht;
    logic               val;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] nseg;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== src/pfde_front.sv =====
`default_nettype none

module pfde_front (
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [pfde_pkg::ACT_W-1:0]         in_action,
  input  wire logic [pfde_pkg::COORD_W-1:0]       in_x_first,
  input  wire logic [pfde_pkg::COORD_W-1:0]       in_y_first,
  input  wire logic [pfde_pkg::COORD_W-1:0]       in_x_second,
  input  wire logic [pfde_pkg::COORD_W-1:0]       in_y_second,
  input  wire logic [pfde_pkg::COORD_W-1:0]       in_run_length,
  input  wire logic                               in_pixel_value,
  input  wire logic [pfde_pkg::IDX_W-1:0]         in_byte_index,
  input  wire pfde_pkg::q_stat_t                  q_stat,
  input  wire logic                               init_busy,
  output logic                                    q_push,
  output pfde_pkg::cmd_t                          q_wdata
);

  logic [pfde_pkg::COORD_W-1:0] rect_w;
  logic [pfde_pkg::COORD_W-1:0] rect_h;

  assign rect_w   = in_x_second - in_x_first + 8'd1;
  assign rect_h   = in_y_second - in_y_first;
  assign in_stall = q_stat.full | init_busy;
  assign q_push   = in_valid & ~in_stall;

  always_comb begin
    q_wdata.xa   = in_x_first;
    q_wdata.ya   = in_y_first;
    q_wdata.xb   = in_x_second;
    q_wdata.yb   = in_y_second;
    q_wdata.ht   = rect_h;
    q_wdata.val  = in_pixel_value;
    q_wdata.idx  = in_byte_index;
    q_wdata.cnt  = rect_w;
    q_wdata.kind = pfde_pkg::K_NOP;
    q_wdata.nseg = 8'd0;
    case (in_action)
      pfde_pkg::ACT_PIXEL: begin
        q_wdata.kind = pfde_pkg::K_PIXEL;
        q_wdata.nseg = 8'd1;
      end
      pfde_pkg::ACT_HLINE: begin
        q_wdata.kind = pfde_pkg::K_HLINE;
        q_wdata.cnt  = in_run_length;
        q_wdata.nseg = 8'd1;
      end
      pfde_pkg::ACT_VLINE: begin
        q_wdata.kind = pfde_pkg::K_VLINE;
        q_wdata.cnt  = in_run_length;
        q_wdata.nseg = 8'd1;
      end
      pfde_pkg::ACT_RECT: begin
        q_wdata.kind = pfde_pkg::K_RECT;
        q_wdata.nseg = 8'd4;
      end
      pfde_pkg::ACT_FILL: begin
        q_wdata.kind = pfde_pkg::K_FILL;
        q_wdata.nseg = rect_w;
      end
      pfde_pkg::ACT_CLEAR: begin
        q_wdata.kind = pfde_pkg::K_CLEAR;
      end
      pfde_pkg::ACT_READ: begin
        q_wdata.kind = pfde_pkg::K_READ;
      end
      default: begin
        q_wdata.kind = pfde_pkg::K_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pfde_queue.sv =====
`default_nettype none

module pfde_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pfde_pkg::cmd_t wdata,
  input  wire logic           pop,
  output pfde_pkg::cmd_t      rdata,
  output pfde_pkg::q_stat_t   stat
);

  pfde_pkg::cmd_t                 slot_r [pfde_pkg::QUEUE_DEPTH];
  logic [pfde_pkg::QPTR_W-1:0]    wptr_r;
  logic [pfde_pkg::QPTR_W-1:0]    rptr_r;
  logic [pfde_pkg::QPTR_W:0]      count_r;
  logic [pfde_pkg::QPTR_W-1:0]    wptr_nxt;
  logic [pfde_pkg::QPTR_W-1:0]    rptr_nxt;
  logic [pfde_pkg::QPTR_W:0]      count_nxt;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == (pfde_pkg::QPTR_W+1)'(pfde_pkg::QUEUE_DEPTH));
  assign rdata      = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == (pfde_pkg::QPTR_W)'(pfde_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == (pfde_pkg::QPTR_W)'(pfde_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfde_back.sv =====
`default_nettype none

module pfde_back #(
  parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pfde_pkg::q_stat_t            q_stat,
  input  wire pfde_pkg::cmd_t               q_rdata,
  output logic                              q_pop,
  output logic                              init_busy,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pfde_pkg::COORD_W-1:0]      out_read_data,
  output logic                              out_command_done
);

  localparam int RowW  = $clog2(SCREEN_WIDTH + 1);
  localparam int AddrW = (6 + RowW > pfde_pkg::STORE_AW + 1) ? 6 + RowW
                         : pfde_pkg::STORE_AW + 1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SEG,
    S_PIX,
    S_WR,
    S_RD,
    S_DONE
  } state_t;

  state_t                          state_r;
  pfde_pkg::cmd_t                  cmd_r;
  logic                            init_r;
  logic [pfde_pkg::STORE_AW-1:0]   clr_cnt_r;
  logic [pfde_pkg::COORD_W-1:0]    seg_r;
  logic [pfde_pkg::COORD_W:0]      step_r;
  logic [pfde_pkg::COORD_W:0]      seg_len_r;
  logic [pfde_pkg::COORD_W-1:0]    sx_r;
  logic [pfde_pkg::COORD_W-1:0]    sy_r;
  logic                            vert_r;
  logic                            set_r;
  logic [pfde_pkg::STORE_AW-1:0]   addr_r;
  logic [pfde_pkg::COORD_W-1:0]    mask_r;
  logic [pfde_pkg::COORD_W-1:0]    res_r;
  logic                            out_valid_r;
  logic [pfde_pkg::COORD_W-1:0]    out_data_r;

  logic [pfde_pkg::COORD_W:0]      seg_len_nxt;
  logic [pfde_pkg::COORD_W-1:0]    sx_nxt;
  logic [pfde_pkg::COORD_W-1:0]    sy_nxt;
  logic                            vert_nxt;
  logic                            set_nxt;

  logic [pfde_pkg::COORD_W-1:0]    store_r [pfde_pkg::STORE_DEPTH];
  logic [pfde_pkg::COORD_W-1:0]    rdata_r;

  logic [pfde_pkg::COORD_W-1:0]    px;
  logic [pfde_pkg::COORD_W-1:0]    py;
  logic [AddrW-1:0]                addr_full;
  logic                            hit;
  logic                            mem_re;
  logic [pfde_pkg::STORE_AW-1:0]   mem_raddr;
  logic                            mem_we;
  logic [pfde_pkg::STORE_AW-1:0]   mem_waddr;
  logic [pfde_pkg::COORD_W-1:0]    mem_wdata;
  logic                            out_load;

  assign px = vert_r ? sx_r : sx_r + step_r[pfde_pkg::COORD_W-1:0];
  assign py = vert_r ? sy_r + step_r[pfde_pkg::COORD_W-1:0] : sy_r;
  assign addr_full = AddrW'(px) + AddrW'(py[7:3]) * AddrW'(SCREEN_WIDTH);
  assign hit = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT))
               && (addr_full < AddrW'(pfde_pkg::STORE_DEPTH));

  assign q_pop     = (state_r == S_IDLE) && q_stat.valid;
  assign init_busy = init_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_command_done = 1'b1;

  // start point, direction, length and pixel value of the next segment
  always_comb begin
    sx_nxt      = cmd_r.xa;
    sy_nxt      = cmd_r.ya;
    vert_nxt    = 1'b0;
    set_nxt     = 1'b1;
    seg_len_nxt = {1'b0, cmd_r.cnt};
    case (cmd_r.kind)
      pfde_pkg::K_PIXEL: begin
        seg_len_nxt = 9'd1;
        set_nxt     = cmd_r.val;
      end
      pfde_pkg::K_VLINE: begin
        vert_nxt = 1'b1;
      end
      pfde_pkg::K_RECT: begin
        case (seg_r[1:0])
          2'd1: sy_nxt = cmd_r.yb;
          2'd2: begin
            vert_nxt    = 1'b1;
            seg_len_nxt = {1'b0, cmd_r.ht};
          end
          2'd3: begin
            sx_nxt      = cmd_r.xb;
            vert_nxt    = 1'b1;
            seg_len_nxt = {1'b0, cmd_r.ht};
          end
          default: sy_nxt = cmd_r.ya;
        endcase
      end
      pfde_pkg::K_FILL: begin
        sx_nxt      = cmd_r.xa + seg_r;
        vert_nxt    = 1'b1;
        seg_len_nxt = {1'b0, cmd_r.ht} + 9'd1;
      end
      default: begin
        vert_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr_full[pfde_pkg::STORE_AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = set_r ? (rdata_r | mask_r) : (rdata_r & ~mask_r);
    case (state_r)
      S_IDLE: begin
        mem_re    = q_stat.valid && (q_rdata.kind == pfde_pkg::K_READ);
        mem_raddr = q_rdata.idx;
      end
      S_PIX: begin
        mem_re = (step_r != seg_len_r) && hit;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            init_r  <= 1'b0;
            state_r <= init_r ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (q_stat.valid) begin
            cmd_r <= q_rdata;
            res_r <= '0;
            seg_r <= '0;
            case (q_rdata.kind)
              pfde_pkg::K_CLEAR: begin
                clr_cnt_r <= '0;
                state_r   <= S_CLR;
              end
              pfde_pkg::K_READ: state_r <= S_RD;
              pfde_pkg::K_NOP:  state_r <= S_DONE;
              default:          state_r <= S_SEG;
            endcase
          end
        end
        S_SEG: begin
          if (seg_r == cmd_r.nseg) begin
            state_r <= S_DONE;
          end else begin
            seg_r     <= seg_r + 1'b1;
            step_r    <= '0;
            sx_r      <= sx_nxt;
            sy_r      <= sy_nxt;
            vert_r    <= vert_nxt;
            set_r     <= set_nxt;
            seg_len_r <= seg_len_nxt;
            state_r   <= S_PIX;
          end
        end
        S_PIX: begin
          if (step_r == seg_len_r) begin
            state_r <= S_SEG;
          end else begin
            step_r <= step_r + 1'b1;
            if (hit) begin
              addr_r  <= addr_full[pfde_pkg::STORE_AW-1:0];
              mask_r  <= 8'd1 << py[2:0];
              state_r <= S_WR;
            end
          end
        end
        S_WR: begin
          state_r <= S_PIX;
        end
        S_RD: begin
          res_r   <= rdata_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/page_framebuffer_draw_engine_unit.sv =====
// Monochrome page frame store (1024 bytes, eight vertical pixels per byte) with a
// command front end, a two-entry command queue and a drawing back end. Each command
// gives one result item. Every touched pixel is a read-modify-write of the single
// port store: an on-screen pixel is read in S_PIX and written back in S_WR, while an
// off-screen pixel is only stepped over in S_PIX. A filled rectangle is drawn as one
// vertical segment per column, a clear sweeps every byte, a byte read passes S_RD.
// After reset the store is swept to zero, with in_stall held high.
`default_nettype none

module page_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pfde_pkg::ACT_W-1:0]    in_action,
  input  wire logic [pfde_pkg::COORD_W-1:0]  in_x_first,
  input  wire logic [pfde_pkg::COORD_W-1:0]  in_y_first,
  input  wire logic [pfde_pkg::COORD_W-1:0]  in_x_second,
  input  wire logic [pfde_pkg::COORD_W-1:0]  in_y_second,
  input  wire logic [pfde_pkg::COORD_W-1:0]  in_run_length,
  input  wire logic                          in_pixel_value,
  input  wire logic [pfde_pkg::IDX_W-1:0]    in_byte_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pfde_pkg::COORD_W-1:0]       out_read_data,
  output logic                               out_command_done
);

  pfde_pkg::q_stat_t q_stat;
  pfde_pkg::cmd_t    q_wdata;
  pfde_pkg::cmd_t    q_rdata;
  logic              q_push;
  logic              q_pop;
  logic              init_busy;

  pfde_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_x_first     (in_x_first),
    .in_y_first     (in_y_first),
    .in_x_second    (in_x_second),
    .in_y_second    (in_y_second),
    .in_run_length  (in_run_length),
    .in_pixel_value (in_pixel_value),
    .in_byte_index  (in_byte_index),
    .q_stat         (q_stat),
    .init_busy      (init_busy),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  pfde_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .init_busy        (init_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_command_done (out_command_done)
  );

endmodule

`default_nettype wire

// ===== src/pfde_checker.sv =====
`default_nettype none

`include "page_framebuffer_draw_engine_unit_defines.svh"

module pfde_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [pfde_pkg::COORD_W-1:0]  out_read_data,
  input wire logic                          out_command_done
);

  // store sweep after reset blocks input
  `PFDE_ASSERT_ALWAYS(a_stall_after_rst, !rst_n |=> in_stall, "input open after reset")
  `PFDE_ASSERT_ALWAYS(a_no_out_after_rst, !rst_n |=> !out_valid, "item out after reset")
  `PFDE_ASSERT(a_done_flag, out_valid |-> out_command_done, "item without done flag")
  `PFDE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled item dropped")
  `PFDE_ASSERT(a_data_hold, out_valid && out_stall |=> $stable(out_read_data), "data moved")

endmodule

bind page_framebuffer_draw_engine_unit pfde_checker u_pfde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_read_data    (out_read_data),
  .out_command_done (out_command_done)
);

`default_nettype wire
